FILE: rtl/core/ske_pkg.sv
// shared types, constants and helpers for the surface kinetics euler update block
package ske_pkg;

  localparam int unsigned DW                = 64;
  localparam int unsigned REACTANT_SLOTS    = 4;
  localparam int unsigned MAX_REACTANTS_DEF = 4;

  // ieee double pieces
  localparam int unsigned MANT_W = 53;
  localparam int unsigned EXP_W  = 13;
  localparam int unsigned ACC_W  = 108;

  localparam logic signed [EXP_W-1:0] EMIN   = -13'sd1022;
  localparam logic signed [EXP_W-1:0] EMAX   = 13'sd1023;
  localparam logic signed [EXP_W-1:0] EBIAS  = 13'sd1023;
  localparam logic signed [EXP_W-1:0] E_TINY = -13'sd1140;

  localparam logic [DW-1:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [DW-1:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [DW-1:0] FP_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [DW-1:0] FP_ZERO     = 64'h0000_0000_0000_0000;

  // configuration registers
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SITE_DENS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b1;
  localparam logic [DW-1:0] SITE_DENS_RST = FP_ONE;
  localparam logic [DW-1:0] TIME_STEP_RST = FP_ZERO;

  // species role codes
  localparam logic [1:0] ROLE_NONE = 2'd0;
  localparam logic [1:0] ROLE_LOSS = 2'd1;
  localparam logic [1:0] ROLE_GAIN = 2'd2;

  typedef struct packed {
    logic [DW-1:0] old_density;
    logic          first_reaction;
    logic [DW-1:0] rxn_rate;
    logic [1:0]    role;
    logic [2:0]    reactant_count;
    logic [DW-1:0] reactant_a;
    logic [DW-1:0] reactant_b;
    logic [DW-1:0] reactant_c;
    logic [DW-1:0] reactant_d;
    logic [3:0]    fold_mask;
    logic          last_reaction;
  } in_item_t;

  typedef struct packed {
    logic [DW-1:0] new_density;
    logic [DW-1:0] density_change;
  } out_item_t;

  typedef enum logic [1:0] {
    FOP_MUL = 2'd0,
    FOP_DIV = 2'd1,
    FOP_ADD = 2'd2
  } fpu_op_e;

  typedef struct packed {
    logic    start;
    fpu_op_e op;
  } fpu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fpu_status_t;

  typedef struct packed {
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [MANT_W-1:0]       mant;
  } fp_unpacked_t;

  function automatic fp_unpacked_t fp_unpack(logic [DW-1:0] x);
    fp_unpacked_t u;
    u.sign = x[63];
    u.mant = {(x[62:52] != 11'd0), x[51:0]};
    if (x[62:52] == 11'd0) begin
      u.exp = EMIN;
    end else begin
      u.exp = $signed({2'b00, x[62:52]}) - EBIAS;
    end
    return u;
  endfunction

  function automatic logic fp_is_nan(logic [DW-1:0] x);
    return (&x[62:52]) && (|x[51:0]);
  endfunction

  function automatic logic fp_is_inf(logic [DW-1:0] x);
    return (&x[62:52]) && !(|x[51:0]);
  endfunction

  function automatic logic fp_is_zero(logic [DW-1:0] x);
    return !(|x[62:0]);
  endfunction

endpackage

FILE: rtl/core/ske_fpu.sv
// shared iterative double precision unit: multiply, divide and add; multiply and divide go one bit per cycle
module ske_fpu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ske_pkg::fpu_req_t     req_i,
  input  logic [ske_pkg::DW-1:0] a_i,
  input  logic [ske_pkg::DW-1:0] b_i,
  output ske_pkg::fpu_status_t  status_o,
  output logic [ske_pkg::DW-1:0] res_o
);
  import ske_pkg::*;

  localparam int unsigned SHW = $clog2(ACC_W);

  typedef enum logic [6:0] {
    F_IDLE    = 7'b0000001,
    F_PRENORM = 7'b0000010,
    F_MULT    = 7'b0000100,
    F_DIVIDE  = 7'b0001000,
    F_ALIGN   = 7'b0010000,
    F_NORM    = 7'b0100000,
    F_ROUND   = 7'b1000000
  } fpu_state_e;

  fpu_state_e st_q, st_d;
  logic done_q, done_d;
  logic [DW-1:0] res_q, res_d;
  logic sign_q, sign_d;
  logic effsub_q, effsub_d;
  logic signed [EXP_W-1:0] exp_q, exp_d, expb_q, expb_d;
  logic [ACC_W-1:0] m_q, m_d;
  logic sticky_q, sticky_d;
  logic [MANT_W:0] opa_q, opa_d;
  logic [MANT_W-1:0] opb_q, opb_d;
  logic [5:0] cnt_q, cnt_d;

  fp_unpacked_t ua, ub;
  logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sx, a_ge;

  logic [2*MANT_W-1:0] mul_next;
  logic div_ge;
  logic [MANT_W:0] div_diff;

  logic signed [EXP_W-1:0] al_d;
  logic [ACC_W-1:0] al_big, al_small, al_shift, al_mask, al_jam, al_sum;
  logic al_lost;

  logic [MANT_W-1:0] rnd_mant;
  logic rnd_guard, rnd_st, rnd_inc, rnd_norm;
  logic [MANT_W:0] rnd_sum;
  logic signed [EXP_W-1:0] rnd_exp, rnd_bexp;
  logic [MANT_W-2:0] rnd_frac;

  assign ua     = fp_unpack(a_i);
  assign ub     = fp_unpack(b_i);
  assign nan_a  = fp_is_nan(a_i);
  assign nan_b  = fp_is_nan(b_i);
  assign inf_a  = fp_is_inf(a_i);
  assign inf_b  = fp_is_inf(b_i);
  assign zero_a = fp_is_zero(a_i);
  assign zero_b = fp_is_zero(b_i);
  assign sx     = a_i[63] ^ b_i[63];
  assign a_ge   = a_i[62:0] >= b_i[62:0];

  // shift-and-add multiply, multiplier msb first
  assign mul_next = {m_q[2*MANT_W-2:0], 1'b0}
                  + (opb_q[MANT_W-1] ? {{MANT_W{1'b0}}, opa_q[MANT_W-1:0]}
                                     : {(2*MANT_W){1'b0}});

  // restoring divide step
  assign div_ge   = opa_q >= {1'b0, opb_q};
  assign div_diff = div_ge ? opa_q - {1'b0, opb_q} : opa_q;

  // alignment, jammed sticky in the lsb
  assign al_d     = exp_q - expb_q;
  assign al_big   = {1'b0, opa_q[MANT_W-1:0], {(ACC_W-MANT_W-1){1'b0}}};
  assign al_small = {1'b0, opb_q, {(ACC_W-MANT_W-1){1'b0}}};
  always_comb begin
    if (al_d >= EXP_W'(ACC_W)) begin
      al_shift = '0;
      al_mask  = '1;
      al_lost  = |opb_q;
    end else begin
      al_shift = al_small >> al_d[SHW-1:0];
      al_mask  = ~({ACC_W{1'b1}} << al_d[SHW-1:0]);
      al_lost  = |(al_small & al_mask);
    end
  end
  assign al_jam = {al_shift[ACC_W-1:1], al_shift[0] | al_lost};
  assign al_sum = effsub_q ? al_big - al_jam : al_big + al_jam;

  // round to nearest even
  assign rnd_mant  = m_q[ACC_W-1 -: MANT_W];
  assign rnd_guard = m_q[ACC_W-MANT_W-1];
  assign rnd_st    = (|m_q[ACC_W-MANT_W-2:0]) | sticky_q;
  assign rnd_inc   = rnd_guard & (rnd_st | rnd_mant[0]);
  assign rnd_sum   = {1'b0, rnd_mant} + {{MANT_W{1'b0}}, rnd_inc};
  assign rnd_exp   = rnd_sum[MANT_W] ? exp_q + 13'sd1 : exp_q;
  assign rnd_bexp  = rnd_exp + EBIAS;
  assign rnd_norm  = rnd_sum[MANT_W] | rnd_sum[MANT_W-1];
  assign rnd_frac  = rnd_sum[MANT_W] ? '0 : rnd_sum[MANT_W-2:0];

  always_comb begin
    st_d     = st_q;
    done_d   = 1'b0;
    res_d    = res_q;
    sign_d   = sign_q;
    effsub_d = effsub_q;
    exp_d    = exp_q;
    expb_d   = expb_q;
    m_d      = m_q;
    sticky_d = sticky_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    cnt_d    = cnt_q;

    unique case (st_q)
      F_IDLE: begin
        if (req_i.start) begin
          sticky_d = 1'b0;
          cnt_d    = '0;
          m_d      = '0;
          unique case (req_i.op)
            FOP_MUL: begin
              done_d = 1'b1;
              if (nan_a) begin
                res_d = a_i | QUIET_BIT;
              end else if (nan_b) begin
                res_d = b_i | QUIET_BIT;
              end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                res_d = DEFAULT_NAN;
              end else if (inf_a || inf_b) begin
                res_d = {sx, 11'h7FF, 52'd0};
              end else if (zero_a || zero_b) begin
                res_d = {sx, 63'd0};
              end else begin
                done_d = 1'b0;
                sign_d = sx;
                opa_d  = {1'b0, ua.mant};
                opb_d  = ub.mant;
                exp_d  = ua.exp + ub.exp + 13'sd1;
                st_d   = F_MULT;
              end
            end
            FOP_DIV: begin
              done_d = 1'b1;
              if (nan_a) begin
                res_d = a_i | QUIET_BIT;
              end else if (nan_b) begin
                res_d = b_i | QUIET_BIT;
              end else if ((inf_a && inf_b) || (zero_a && zero_b)) begin
                res_d = DEFAULT_NAN;
              end else if (inf_a || zero_b) begin
                res_d = {sx, 11'h7FF, 52'd0};
              end else if (inf_b || zero_a) begin
                res_d = {sx, 63'd0};
              end else begin
                done_d = 1'b0;
                sign_d = sx;
                opa_d  = {1'b0, ua.mant};
                opb_d  = ub.mant;
                exp_d  = ua.exp;
                expb_d = ub.exp;
                st_d   = F_PRENORM;
              end
            end
            FOP_ADD: begin
              done_d = 1'b1;
              if (nan_a) begin
                res_d = a_i | QUIET_BIT;
              end else if (nan_b) begin
                res_d = b_i | QUIET_BIT;
              end else if (inf_a && inf_b && sx) begin
                res_d = DEFAULT_NAN;
              end else if (inf_a) begin
                res_d = a_i;
              end else if (inf_b) begin
                res_d = b_i;
              end else begin
                done_d   = 1'b0;
                effsub_d = sx;
                // larger magnitude goes to the a side
                if (a_ge) begin
                  sign_d = a_i[63];
                  opa_d  = {1'b0, ua.mant};
                  opb_d  = ub.mant;
                  exp_d  = ua.exp;
                  expb_d = ub.exp;
                end else begin
                  sign_d = b_i[63];
                  opa_d  = {1'b0, ub.mant};
                  opb_d  = ua.mant;
                  exp_d  = ub.exp;
                  expb_d = ua.exp;
                end
                st_d = F_ALIGN;
              end
            end
            default: begin
              done_d = 1'b1;
              res_d  = DEFAULT_NAN;
            end
          endcase
        end
      end

      F_PRENORM: begin
        // bring subnormal mantissas up to a leading one
        if (!opa_q[MANT_W-1]) begin
          opa_d = {opa_q[MANT_W-1:0], 1'b0};
          exp_d = exp_q - 13'sd1;
        end
        if (!opb_q[MANT_W-1]) begin
          opb_d  = {opb_q[MANT_W-2:0], 1'b0};
          expb_d = expb_q - 13'sd1;
        end
        if (opa_q[MANT_W-1] && opb_q[MANT_W-1]) begin
          exp_d = exp_q - expb_q;
          cnt_d = '0;
          m_d   = '0;
          st_d  = F_DIVIDE;
        end
      end

      F_MULT: begin
        opb_d = {opb_q[MANT_W-2:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(MANT_W-1)) begin
          m_d  = {mul_next, 2'b00};
          st_d = F_NORM;
        end else begin
          m_d = {2'b00, mul_next};
        end
      end

      F_DIVIDE: begin
        opa_d = {div_diff[MANT_W-1:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(MANT_W+3)) begin
          // 57 quotient bits, weight of the first one is 2^0
          m_d      = {m_q[MANT_W+2:0], div_ge, {(ACC_W-MANT_W-4){1'b0}}};
          sticky_d = |div_diff;
          st_d     = F_NORM;
        end else begin
          m_d = {m_q[ACC_W-2:0], div_ge};
        end
      end

      F_ALIGN: begin
        if (al_sum == '0) begin
          // exact cancellation gives +0, two zeros of one sign keep it
          res_d  = {effsub_q ? 1'b0 : sign_q, 63'd0};
          done_d = 1'b1;
          st_d   = F_IDLE;
        end else begin
          m_d      = al_sum;
          exp_d    = exp_q + 13'sd1;
          sticky_d = 1'b0;
          st_d     = F_NORM;
        end
      end

      F_NORM: begin
        if (exp_q < E_TINY) begin
          sticky_d = sticky_q | (|m_q);
          m_d      = '0;
          exp_d    = EMIN;
        end else if (exp_q < EMIN) begin
          sticky_d = sticky_q | m_q[0];
          m_d      = {1'b0, m_q[ACC_W-1:1]};
          exp_d    = exp_q + 13'sd1;
        end else if (!m_q[ACC_W-1] && (exp_q > EMIN)) begin
          m_d   = {m_q[ACC_W-2:0], 1'b0};
          exp_d = exp_q - 13'sd1;
        end else begin
          st_d = F_ROUND;
        end
      end

      F_ROUND: begin
        if (rnd_exp > EMAX) begin
          res_d = {sign_q, 11'h7FF, 52'd0};
        end else if (rnd_norm) begin
          res_d = {sign_q, rnd_bexp[10:0], rnd_frac};
        end else begin
          res_d = {sign_q, 11'd0, rnd_frac};
        end
        done_d = 1'b1;
        st_d   = F_IDLE;
      end

      default: begin
        st_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    sign_q   <= sign_d;
    effsub_q <= effsub_d;
    exp_q    <= exp_d;
    expb_q   <= expb_d;
    m_q      <= m_d;
    sticky_q <= sticky_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    cnt_q    <= cnt_d;
  end

  assign status_o.busy = (st_q != F_IDLE);
  assign status_o.done = done_q;
  assign res_o         = res_q;

endmodule

FILE: rtl/core/surface_kinetics_euler_update.sv
// top level: reaction record sequencer around the shared double precision unit
//
// Explicit Euler update of one surface species on one surface element. The host
// sends one transaction per reaction; a record with a positive rate and a loss or
// gain role adds (product of unfolded reactants) * (+-rate / site density) to the
// accumulated change, and the record flagged last emits old + change * dt together
// with the change itself. All arithmetic is IEEE double, round to nearest even,
// done by one iterative unit that multiplies, divides and adds; it multiplies and
// divides one bit per cycle and normalizes one bit position per cycle. A record
// is taken only while the sequencer is idle. A finished result waits in the
// output register while the next record is already being worked on.
module surface_kinetics_euler_update #(
  parameter int unsigned MAX_REACTANTS = ske_pkg::MAX_REACTANTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // record channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ske_pkg::in_item_t           in_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ske_pkg::out_item_t          out_data_o,
  // register writes
  input  logic                        cfg_we_i,
  input  logic [ske_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ske_pkg::DW-1:0]      cfg_data_i
);
  import ske_pkg::*;

  // reactant slots actually kept
  localparam int unsigned SLOTS = (MAX_REACTANTS < REACTANT_SLOTS) ? MAX_REACTANTS
                                                                    : REACTANT_SLOTS;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SCAN     = 10'b0000000010,
    S_MUL_W    = 10'b0000000100,
    S_DIV_W    = 10'b0000001000,
    S_MULQ_W   = 10'b0000010000,
    S_ACC_W    = 10'b0000100000,
    S_DT_ISSUE = 10'b0001000000,
    S_DT_W     = 10'b0010000000,
    S_OUT_W    = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } seq_state_e;

  seq_state_e st_q, st_d;

  // configuration
  logic [DW-1:0] site_dens_q, time_step_q;

  // element state
  logic [DW-1:0] acc_q, held_q;

  // current record
  logic [DW-1:0] rate_q, term_q, newd_q;
  logic [1:0]    role_q;
  logic          last_q;
  logic [CW-1:0] rem_q;
  logic [SLOTS-1:0] mask_q;
  logic [DW-1:0] react_q [SLOTS];
  logic [DW-1:0] in_react [REACTANT_SLOTS];

  // result register
  logic      out_valid_q;
  out_item_t out_data_q;

  // shared unit
  fpu_req_t    fpu_req;
  fpu_status_t fpu_stat;
  logic [DW-1:0] fpu_a, fpu_b, fpu_res;

  logic in_acc, contrib, rate_pos;
  logic shift_en, term_ld, acc_ld, newd_ld, out_ld;
  logic [CW-1:0] count_sat;

  assign in_ready_o = (st_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign in_react[0] = in_data_i.reactant_a;
  assign in_react[1] = in_data_i.reactant_b;
  assign in_react[2] = in_data_i.reactant_c;
  assign in_react[3] = in_data_i.reactant_d;

  // strictly positive, not a nan
  assign rate_pos = !in_data_i.rxn_rate[63]
                 && !fp_is_zero(in_data_i.rxn_rate)
                 && !fp_is_nan(in_data_i.rxn_rate);
  assign contrib  = rate_pos
                 && ((in_data_i.role == ROLE_LOSS) || (in_data_i.role == ROLE_GAIN));

  // count above the slot limit saturates
  assign count_sat = (in_data_i.reactant_count > 3'(SLOTS)) ? CW'(SLOTS)
                                                            : in_data_i.reactant_count[CW-1:0];

  // sequencer
  always_comb begin
    st_d        = st_q;
    fpu_req     = '{start: 1'b0, op: FOP_MUL};
    fpu_a       = term_q;
    fpu_b       = react_q[0];
    shift_en    = 1'b0;
    term_ld     = 1'b0;
    acc_ld      = 1'b0;
    newd_ld     = 1'b0;
    out_ld      = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          if (contrib) begin
            st_d = S_SCAN;
          end else if (in_data_i.last_reaction) begin
            st_d = S_DT_ISSUE;
          end
        end
      end
      S_SCAN: begin
        if (rem_q == '0) begin
          // signed rate over site density
          fpu_req = '{start: 1'b1, op: FOP_DIV};
          fpu_a   = {(role_q == ROLE_LOSS), rate_q[62:0]};
          fpu_b   = site_dens_q;
          st_d    = S_DIV_W;
        end else begin
          shift_en = 1'b1;
          if (!mask_q[0]) begin
            fpu_req = '{start: 1'b1, op: FOP_MUL};
            st_d    = S_MUL_W;
          end
        end
      end
      S_MUL_W: begin
        if (fpu_stat.done) begin
          term_ld = 1'b1;
          st_d    = S_SCAN;
        end
      end
      S_DIV_W: begin
        if (fpu_stat.done) begin
          fpu_req = '{start: 1'b1, op: FOP_MUL};
          fpu_b   = fpu_res;
          st_d    = S_MULQ_W;
        end
      end
      S_MULQ_W: begin
        if (fpu_stat.done) begin
          fpu_req = '{start: 1'b1, op: FOP_ADD};
          fpu_a   = acc_q;
          fpu_b   = fpu_res;
          st_d    = S_ACC_W;
        end
      end
      S_ACC_W: begin
        if (fpu_stat.done) begin
          acc_ld = 1'b1;
          if (last_q) begin
            fpu_req = '{start: 1'b1, op: FOP_MUL};
            fpu_a   = fpu_res;
            fpu_b   = time_step_q;
            st_d    = S_DT_W;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      S_DT_ISSUE: begin
        fpu_req = '{start: 1'b1, op: FOP_MUL};
        fpu_a   = acc_q;
        fpu_b   = time_step_q;
        st_d    = S_DT_W;
      end
      S_DT_W: begin
        if (fpu_stat.done) begin
          fpu_req = '{start: 1'b1, op: FOP_ADD};
          fpu_a   = held_q;
          fpu_b   = fpu_res;
          st_d    = S_OUT_W;
        end
      end
      S_OUT_W: begin
        if (fpu_stat.done) begin
          newd_ld = 1'b1;
          st_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        // wait for room in the result register
        if (!out_valid_q || out_ready_i) begin
          out_ld = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  ske_fpu u_fpu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (fpu_req),
    .a_i      (fpu_a),
    .b_i      (fpu_b),
    .status_o (fpu_stat),
    .res_o    (fpu_res)
  );

  // control and state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      site_dens_q <= SITE_DENS_RST;
      time_step_q <= TIME_STEP_RST;
      acc_q       <= FP_ZERO;
      held_q      <= FP_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SITE_DENS: site_dens_q <= cfg_data_i;
          REG_TIME_STEP: time_step_q <= cfg_data_i;
          default: ;
        endcase
      end
      // new element clears the change and takes the old density
      if (in_acc && in_data_i.first_reaction) begin
        held_q <= in_data_i.old_density;
        acc_q  <= FP_ZERO;
      end else if (acc_ld) begin
        acc_q <= fpu_res;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // record payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rate_q <= in_data_i.rxn_rate;
      role_q <= in_data_i.role;
      last_q <= in_data_i.last_reaction;
      rem_q  <= count_sat;
      mask_q <= in_data_i.fold_mask[SLOTS-1:0];
      term_q <= FP_ONE;
      for (int i = 0; i < SLOTS; i++) begin
        react_q[i] <= in_react[i];
      end
    end else begin
      if (shift_en) begin
        // next reactant moves into slot zero
        rem_q  <= rem_q - CW'(1);
        mask_q <= mask_q >> 1;
        for (int i = 0; i < SLOTS - 1; i++) begin
          react_q[i] <= react_q[i+1];
        end
      end
      if (term_ld) begin
        term_q <= fpu_res;
      end
    end
    if (newd_ld) begin
      newd_q <= fpu_res;
    end
    if (out_ld) begin
      out_data_q.new_density    <= newd_q;
      out_data_q.density_change <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_req.start |-> !fpu_stat.busy)
    else $error("operation issued while the shared unit is busy");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_stat.done |-> (st_q == S_MUL_W || st_q == S_DIV_W || st_q == S_MULQ_W ||
                       st_q == S_ACC_W || st_q == S_DT_W || st_q == S_OUT_W))
    else $error("shared unit finished while the sequencer was not waiting");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EMIT && !out_valid_q) |=> (out_valid_q && st_q == S_IDLE))
    else $error("result not loaded into a free output register");
`endif

endmodule

FILE: test/surface_kinetics_euler_update_tb.sv
// testbench for the surface kinetics euler update block with a self-checking scoreboard
`timescale 1ns / 1ps

module surface_kinetics_euler_update_tb;
  import ske_pkg::*;

  // role code 3 is unused and must contribute nothing
  localparam logic [1:0] ROLE_UNUSED = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned DRAIN_CYCLES = 3000;
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  // expected densities plus a private copy of the block's registers and state
  class density_scoreboard;
    out_item_t    expected_q[$];
    logic [63:0]  site_dens;
    logic [63:0]  time_step;
    logic [63:0]  change_acc;
    logic [63:0]  held_density;

    function void clear();
      expected_q.delete();
      site_dens    = SITE_DENS_RST;
      time_step    = TIME_STEP_RST;
      change_acc   = FP_ZERO;
      held_density = FP_ZERO;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      if (idx == REG_SITE_DENS) site_dens = val;
      else if (idx == REG_TIME_STEP) time_step = val;
    endfunction

    // division with the zero-divisor cases spelled out
    function real safe_div(real x, logic [63:0] yb);
      logic [63:0] xb;
      real         y;
      xb = $realtobits(x);
      y  = $bitstoreal(yb);
      if (y != 0.0) return x / y;
      if (x != x) return $bitstoreal(xb | QUIET_BIT);
      if (x == 0.0) return $bitstoreal(DEFAULT_NAN);
      return $bitstoreal(64'h7FF0_0000_0000_0000 | ((xb ^ yb) & 64'h8000_0000_0000_0000));
    endfunction

    // accepted record: update the accumulator and queue a result on the last record
    function void note_record(in_item_t it);
      real         acc;
      real         rate;
      real         term;
      int unsigned cnt;
      logic [63:0] vals [4];
      out_item_t   res;
      if (it.first_reaction) begin
        held_density = it.old_density;
        change_acc   = FP_ZERO;
      end
      acc  = $bitstoreal(change_acc);
      rate = $bitstoreal(it.rxn_rate);
      cnt  = (it.reactant_count > 4) ? 4 : it.reactant_count;
      vals[0] = it.reactant_a;
      vals[1] = it.reactant_b;
      vals[2] = it.reactant_c;
      vals[3] = it.reactant_d;
      if (rate > 0.0 && (it.role == ROLE_LOSS || it.role == ROLE_GAIN)) begin
        term = 1.0;
        for (int k = 0; k < cnt; k++) begin
          if (!it.fold_mask[k]) term = term * $bitstoreal(vals[k]);
        end
        term = term * safe_div((it.role == ROLE_LOSS) ? -rate : rate, site_dens);
        acc = acc + term;
        change_acc = $realtobits(acc);
      end
      if (it.last_reaction) begin
        res.new_density    = $realtobits($bitstoreal(held_density)
                                         + acc * $bitstoreal(time_step));
        res.density_change = change_acc;
        expected_q.push_back(res);
      end
    endfunction

    // returns a mismatch mask: bit 2 unexpected, bit 1 new density, bit 0 change
    function logic [2:0] check_result(out_item_t got, output out_item_t exp);
      logic [2:0] bad;
      bad = '0;
      exp = '0;
      if (expected_q.size() == 0) return 3'b100;
      exp = expected_q.pop_front();
      if (!same_double(got.new_density, exp.new_density)) bad[1] = 1'b1;
      if (!same_double(got.density_change, exp.density_change)) bad[0] = 1'b1;
      return bad;
    endfunction

    // nan payloads are not pinned down by the host arithmetic, so any nan matches a nan
    function bit same_double(logic [63:0] a, logic [63:0] b);
      if (fp_is_nan(b)) return fp_is_nan(a);
      return a === b;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [63:0]        cfg_data_i = '0;

  density_scoreboard  sb;
  int unsigned        mismatches = 0;
  int unsigned        idle_cycles = 0;
  bit                 calm = 1'b0;       // no idling in the closing part of the run

  surface_kinetics_euler_update uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] exp);
    mismatches++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
  endtask

  // result side: check every transaction, stall the receiver in random bursts
  initial begin
    int unsigned stall_left;
    logic [2:0]  bad;
    out_item_t   exp;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        bad = sb.check_result(out_data_o, exp);
        if (bad[2]) report("unexpected result", out_data_o.new_density, '0);
        if (bad[1]) report("new_density", out_data_o.new_density, exp.new_density);
        if (bad[0]) report("density_change", out_data_o.density_change, exp.density_change);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly moderate normal values, some raw bit patterns and some special values
  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    case ($urandom_range(0, 15))
      0: v = {$urandom, $urandom};
      1: begin
        case ($urandom_range(0, 7))
          0: v = 64'h0000_0000_0000_0000;
          1: v = 64'h8000_0000_0000_0000;
          2: v = 64'h7FF0_0000_0000_0000;
          3: v = 64'hFFF0_0000_0000_0000;
          4: v = 64'h7FEF_FFFF_FFFF_FFFF;
          5: v = 64'h0000_0000_0000_0001;
          6: v = 64'h000F_FFFF_FFFF_FFFF;
          default: v = FP_ONE;
        endcase
      end
      default: begin
        v[63]    = 1'($urandom_range(0, 1));
        v[62:52] = 11'($urandom_range(1003, 1043));
        v[51:0]  = 52'({$urandom, $urandom});
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t rand_record(bit first, bit last);
    in_item_t it;
    it.old_density    = rand_double();
    it.first_reaction = first;
    it.rxn_rate       = rand_double();
    if ($urandom_range(0, 4) != 0) it.rxn_rate[63] = 1'b0;
    case ($urandom_range(0, 9))
      0: it.role = ROLE_NONE;
      1: it.role = ROLE_UNUSED;
      2, 3, 4, 5: it.role = ROLE_LOSS;
      default: it.role = ROLE_GAIN;
    endcase
    it.reactant_count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
    it.reactant_a     = rand_double();
    it.reactant_b     = rand_double();
    it.reactant_c     = rand_double();
    it.reactant_d     = rand_double();
    it.fold_mask      = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd0;
    it.last_reaction  = last;
    return it;
  endfunction

  // call at a clock edge; returns at the edge that accepted the record
  task automatic send_record(in_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_record(it);
  endtask

  // stop sending, let every result come back, then let a silent record finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // random traffic: mostly well formed elements, some loose records
  task automatic random_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 6) != 0) begin
        len = $urandom_range(1, 5);
        for (int unsigned r = 0; r < len; r++) begin
          send_record(rand_record(r == 0, r == len - 1));
          sent++;
        end
      end else begin
        send_record(rand_record(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  initial begin
    in_item_t it;
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers give dt = 0, so new density is the held density
    it = rand_record(1'b1, 1'b1);
    it.rxn_rate = FP_ONE; it.role = ROLE_GAIN; it.reactant_count = 3'd0;
    send_record(it);
    drain();

    write_reg(REG_SITE_DENS, 64'h4000_0000_0000_0000);
    write_reg(REG_TIME_STEP, 64'h3FB9_9999_9999_999A);

    // rate zero, negative and nan, role none and unused, in one element
    it = rand_record(1'b1, 1'b0); it.rxn_rate = 64'h0;                   send_record(it);
    it = rand_record(1'b0, 1'b0); it.rxn_rate = 64'h8000_0000_0000_0000; send_record(it);
    it = rand_record(1'b0, 1'b0); it.rxn_rate = 64'hBFF0_0000_0000_0000; send_record(it);
    it = rand_record(1'b0, 1'b0); it.rxn_rate = 64'h7FF8_0000_0000_0001; send_record(it);
    it = rand_record(1'b0, 1'b0); it.rxn_rate = FP_ONE; it.role = ROLE_NONE;
    send_record(it);
    it = rand_record(1'b0, 1'b1); it.rxn_rate = FP_ONE; it.role = ROLE_UNUSED;
    send_record(it);
    // loss and gain with every reactant count, saturation above four and folded reactants
    for (int c = 0; c < 8; c++) begin
      it = rand_record(c == 0, c == 7);
      it.rxn_rate = 64'h3FF8_0000_0000_0000;
      it.role = (c % 2) ? ROLE_LOSS : ROLE_GAIN;
      it.reactant_count = 3'(c);
      it.fold_mask = (c == 6) ? 4'b1010 : ((c == 7) ? 4'b1111 : 4'b0000);
      send_record(it);
    end
    // last record without a first one keeps the held values
    it = rand_record(1'b0, 1'b1); send_record(it);
    // extremes of the wide fields
    it = rand_record(1'b1, 1'b1);
    it.old_density = '1; it.rxn_rate = 64'h7FEF_FFFF_FFFF_FFFF; it.role = ROLE_GAIN;
    it.reactant_count = 3'd4; it.fold_mask = 4'd0;
    it.reactant_a = '1; it.reactant_b = 64'h0; it.reactant_c = 64'h7FF0_0000_0000_0000;
    it.reactant_d = 64'h0000_0000_0000_0001;
    send_record(it);
    drain();

    // zero site density: division by zero gives signed infinities
    write_reg(REG_SITE_DENS, 64'h0);
    write_reg(REG_TIME_STEP, '1);
    it = rand_record(1'b1, 1'b0); it.rxn_rate = FP_ONE; it.role = ROLE_LOSS;
    send_record(it);
    it = rand_record(1'b0, 1'b1); it.rxn_rate = 64'h0000_0000_0000_0001;
    it.role = ROLE_GAIN;
    send_record(it);
    random_phase(ITEMS_PER_PHASE / 2);
    drain();

    // register settings for the random phases, extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SITE_DENS, 64'h3FF0_0000_0000_0000);
          write_reg(REG_TIME_STEP, 64'h3F50_6253_7A0A_1E98);
        end
        1: begin
          write_reg(REG_SITE_DENS, 64'h7FEF_FFFF_FFFF_FFFF);
          write_reg(REG_TIME_STEP, 64'h7FEF_FFFF_FFFF_FFFF);
        end
        2: begin
          write_reg(REG_SITE_DENS, 64'h0000_0000_0000_0001);
          write_reg(REG_TIME_STEP, 64'h8000_0000_0000_0000);
        end
        3: begin
          write_reg(REG_SITE_DENS, {$urandom, $urandom});
          write_reg(REG_TIME_STEP, {$urandom, $urandom});
        end
        default: begin
          write_reg(REG_SITE_DENS, 64'h4341_C379_37E0_8000);
          write_reg(REG_TIME_STEP, 64'h3E11_2E0B_E826_D695);
          calm = 1'b1;
        end
      endcase
      random_phase(ITEMS_PER_PHASE);
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
